// ----- rtl/core/ecn2iso_pkg.sv -----
// ---------------------------------------------------------------------------
// ecn2iso_pkg
// Types and code constants for the GB2312 EUC to ISO-2022-CN encoder.
// ---------------------------------------------------------------------------
package ecn2iso_pkg;

  // Request: one input byte or a flush
  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } req_t;

  // Result: one output byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       illegal_sequence;
  } res_t;

  // Operation codes
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_FLUSH   = 1'b1;

  // Output stream phases
  localparam logic [1:0] PH_ASCII   = 2'd0;
  localparam logic [1:0] PH_LEAD    = 2'd1;
  localparam logic [1:0] PH_PAIR    = 2'd2;
  localparam logic [1:0] PH_SHIFTIN = 2'd3;

  // Control and escape bytes
  localparam logic [7:0] CODE_SI     = 8'h0f;
  localparam logic [7:0] CODE_SO     = 8'h0e;
  localparam logic [7:0] CODE_ESC    = 8'h1b;
  localparam logic [7:0] CODE_DOLLAR = 8'h24;
  localparam logic [7:0] CODE_RPAREN = 8'h29;
  localparam logic [7:0] CODE_A      = 8'h41;
  localparam logic [7:0] LOW7_MASK   = 8'h7f;

  // Longest burst per request (designation sequence)
  localparam int unsigned BURST_MAX = 5;
  localparam int unsigned CNT_W     = 3;

endpackage

// ----- rtl/core/euc_cn_to_iso2022_cn_encoder.sv -----
// Timing: the first result is registered and visible in the cycle after
// the request is accepted. Throughput: one request per cycle while each
// gives at most one byte and results are not stalled; a longer burst holds
// the buffer until its last byte is taken at the single output byte port.
// Reset: synchronous; phase returns to plain ASCII, lead byte clears and
// the burst buffer empties.
// ---------------------------------------------------------------------------
// euc_cn_to_iso2022_cn_encoder
// Converts a GB2312 EUC byte stream to ISO-2022-CN, one request per byte.
// ---------------------------------------------------------------------------
module euc_cn_to_iso2022_cn_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ecn2iso_pkg::req_t  req,
  output logic               res_valid,
  input  logic               res_ready,
  output ecn2iso_pkg::res_t  res
);
  import ecn2iso_pkg::*;

  // Conversion state
  logic [1:0] phase;
  logic [7:0] lead_byte;
  logic [1:0] phase_next;
  logic [7:0] lead_byte_next;

  // Burst buffer: remaining result bytes, head at index 0
  logic [7:0]       burst [BURST_MAX];
  logic [CNT_W-1:0] cnt;
  logic             err;

  // Burst built from the current request
  logic [7:0]       nb [BURST_MAX];
  logic [CNT_W-1:0] n;
  logic             n_err;

  logic req_take;
  logic res_take;
  logic high;

  assign high      = req.data_byte[7];
  assign res_valid = (cnt != '0);
  assign res_take  = res_valid && res_ready;
  assign req_ready = (cnt == '0) || ((cnt == CNT_W'(1)) && res_ready);
  assign req_take  = req_valid && req_ready;

  assign res.out_byte         = burst[0];
  assign res.last             = (cnt == CNT_W'(1));
  assign res.illegal_sequence = err;

  // Next state and result burst for one request
  always_comb begin
    phase_next     = phase;
    lead_byte_next = lead_byte;
    n              = '0;
    n_err          = 1'b0;
    for (int i = 0; i < BURST_MAX; i++) nb[i] = 8'h00;
    if (req.operation == OP_FLUSH) begin
      if (phase == PH_LEAD || phase == PH_PAIR) begin
        nb[0] = CODE_SI;
        n     = CNT_W'(1);
      end
      phase_next = PH_ASCII;
    end else begin
      unique case (phase)
        PH_ASCII: begin
          if (high) begin
            nb[0] = CODE_ESC;
            nb[1] = CODE_DOLLAR;
            nb[2] = CODE_RPAREN;
            nb[3] = CODE_A;
            nb[4] = CODE_SO;
            n     = CNT_W'(BURST_MAX);
            lead_byte_next = req.data_byte;
            phase_next     = PH_LEAD;
          end else begin
            nb[0] = req.data_byte;
            n     = CNT_W'(1);
          end
        end
        PH_LEAD: begin
          if (high) begin
            nb[0] = lead_byte & LOW7_MASK;
            nb[1] = req.data_byte & LOW7_MASK;
            n     = CNT_W'(2);
            phase_next = PH_PAIR;
          end else begin
            // ASCII while a lead is pending: single error result
            n     = CNT_W'(1);
            n_err = 1'b1;
          end
        end
        PH_PAIR: begin
          if (high) begin
            lead_byte_next = req.data_byte;
            phase_next     = PH_LEAD;
          end else begin
            nb[0] = CODE_SI;
            nb[1] = req.data_byte;
            n     = CNT_W'(2);
            phase_next = PH_SHIFTIN;
          end
        end
        PH_SHIFTIN: begin
          if (high) begin
            nb[0] = CODE_SO;
            n     = CNT_W'(1);
            lead_byte_next = req.data_byte;
            phase_next     = PH_LEAD;
          end else begin
            nb[0] = req.data_byte;
            n     = CNT_W'(1);
          end
        end
        default: begin
          phase_next = PH_ASCII;
        end
      endcase
    end
  end

  // State and buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_ASCII;
      lead_byte <= 8'h00;
      cnt       <= '0;
      err       <= 1'b0;
    end else if (req_take) begin
      phase     <= phase_next;
      lead_byte <= lead_byte_next;
      cnt       <= n;
      err       <= n_err;
    end else if (res_take) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Buffer payload: load on request, shift on each result taken
  always_ff @(posedge clk) begin
    if (req_take) begin
      for (int i = 0; i < BURST_MAX; i++) burst[i] <= nb[i];
    end else if (res_take) begin
      for (int i = 0; i < BURST_MAX - 1; i++) burst[i] <= burst[i + 1];
      burst[BURST_MAX - 1] <= 8'h00;
    end
  end

endmodule

// ----- rtl/core/ecn2iso_checker.sv -----
// ---------------------------------------------------------------------------
// ecn2iso_checker
// Port-level checks for the encoder, bound to the encoder module.
// ---------------------------------------------------------------------------
module ecn2iso_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_ready,
  input logic              res_valid,
  input logic              res_ready,
  input ecn2iso_pkg::res_t res
);
  import ecn2iso_pkg::*;

  // Nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A held result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped before taken");

  // Mid-burst: the next byte follows and no new request enters
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && !res.last) |=> res_valid)
    else $error("burst broken before last byte");

  a_no_req_mid_burst: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |-> !req_ready)
    else $error("request accepted during a burst");

  // Error result is a lone zero byte
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.illegal_sequence) |-> (res.last && res.out_byte == 8'h00))
    else $error("malformed error result");

endmodule

bind euc_cn_to_iso2022_cn_encoder ecn2iso_checker u_ecn2iso_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Checks the EUC-CN to ISO-2022-CN encoder against a behavioral predictor:
// directed byte sequences for each phase transition, then random text.
// ---------------------------------------------------------------------------
module tb;
  import ecn2iso_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  // Predictor state and expected output bytes, oldest first
  logic [1:0] enc_phase = PH_ASCII;
  logic [7:0] enc_lead = 8'h00;
  res_t iso_bytes_due[$];

  int unsigned mismatch_count = 0;
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;

  euc_cn_to_iso2022_cn_encoder dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always #5 clk = ~clk;

  // Idle length: mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    else if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 30);
  endfunction

  function automatic res_t iso_byte(input logic [7:0] b, input logic bad);
    res_t r;
    r.out_byte = b;
    r.last = 1'b0;
    r.illegal_sequence = bad;
    return r;
  endfunction

  // Encoder predictor: queues the bytes one request produces
  task automatic encode_request(input req_t r);
    res_t burst[$];
    logic high;
    high = r.data_byte[7];
    if (r.operation == OP_FLUSH) begin
      // shift back in only when shifted out
      if (enc_phase == PH_LEAD || enc_phase == PH_PAIR)
        burst.push_back(iso_byte(CODE_SI, 1'b0));
      enc_phase = PH_ASCII;
    end else begin
      case (enc_phase)
        PH_ASCII: begin
          if (high) begin
            burst.push_back(iso_byte(CODE_ESC, 1'b0));
            burst.push_back(iso_byte(CODE_DOLLAR, 1'b0));
            burst.push_back(iso_byte(CODE_RPAREN, 1'b0));
            burst.push_back(iso_byte(CODE_A, 1'b0));
            burst.push_back(iso_byte(CODE_SO, 1'b0));
            enc_lead = r.data_byte;
            enc_phase = PH_LEAD;
          end else begin
            burst.push_back(iso_byte(r.data_byte, 1'b0));
          end
        end
        PH_LEAD: begin
          if (high) begin
            burst.push_back(iso_byte(enc_lead & LOW7_MASK, 1'b0));
            burst.push_back(iso_byte(r.data_byte & LOW7_MASK, 1'b0));
            enc_phase = PH_PAIR;
          end else begin
            // ASCII with a lead pending: error, byte dropped
            burst.push_back(iso_byte(8'h00, 1'b1));
          end
        end
        PH_PAIR: begin
          if (high) begin
            enc_lead = r.data_byte;
            enc_phase = PH_LEAD;
          end else begin
            burst.push_back(iso_byte(CODE_SI, 1'b0));
            burst.push_back(iso_byte(r.data_byte, 1'b0));
            enc_phase = PH_SHIFTIN;
          end
        end
        default: begin
          if (high) begin
            burst.push_back(iso_byte(CODE_SO, 1'b0));
            enc_lead = r.data_byte;
            enc_phase = PH_LEAD;
          end else begin
            burst.push_back(iso_byte(r.data_byte, 1'b0));
          end
        end
      endcase
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) iso_bytes_due.push_back(burst[i]);
  endtask

  // Send one request; returns at the edge that accepts it
  task automatic send_request(input logic op, input logic [7:0] b);
    int unsigned gap;
    req_t item;
    gap = (idle_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    item.operation = op;
    item.data_byte = b;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    encode_request(item);
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (iso_bytes_due.size() != 0) @(posedge clk);
  endtask

  // Result sink: random stalls on res_ready
  initial begin
    @(posedge clk);
    forever begin
      if (stall_on && $urandom_range(0, 99) < 25) begin
        res_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
        res_ready <= 1'b1;
      end else begin
        res_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (iso_bytes_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, actual byte=%02h last=%0b illegal=%0b",
                 $time, res.out_byte, res.last, res.illegal_sequence);
      end else begin
        if (res !== iso_bytes_due[0]) begin
          mismatch_count++;
          $display({"%0t: mismatch, expected byte=%02h last=%0b illegal=%0b, ",
                    "actual byte=%02h last=%0b illegal=%0b"},
                   $time, iso_bytes_due[0].out_byte, iso_bytes_due[0].last,
                   iso_bytes_due[0].illegal_sequence, res.out_byte, res.last,
                   res.illegal_sequence);
        end
        void'(iso_bytes_due.pop_front());
      end
    end
  end

  // Plain ASCII echo before any designation
  task automatic test_ascii_echo();
    send_request(OP_CONVERT, 8'h00);
    send_request(OP_CONVERT, 8'h7f);
    send_request(OP_CONVERT, 8'h55);
  endtask

  // Designation, pairs, silent lead, shift-in and shift-out
  task automatic test_double_byte();
    send_request(OP_CONVERT, 8'ha1);
    send_request(OP_CONVERT, 8'hfe);
    send_request(OP_CONVERT, 8'h80);
    send_request(OP_CONVERT, 8'hff);
    send_request(OP_CONVERT, 8'h00);
    send_request(OP_CONVERT, 8'h7f);
    send_request(OP_CONVERT, 8'hb0);
    send_request(OP_CONVERT, 8'hc1);
  endtask

  // ASCII while a lead byte is pending
  task automatic test_illegal_ascii();
    send_request(OP_CONVERT, 8'hd6);
    send_request(OP_CONVERT, 8'h20);
    send_request(OP_CONVERT, 8'h7f);
    send_request(OP_CONVERT, 8'haa);
  endtask

  // Flush from every phase
  task automatic test_flush();
    send_request(OP_FLUSH, 8'h00);
    send_request(OP_FLUSH, 8'hff);
    send_request(OP_CONVERT, 8'h80);
    send_request(OP_FLUSH, 8'h3c);
    send_request(OP_CONVERT, 8'h0a);
    send_request(OP_CONVERT, 8'hc4);
    send_request(OP_CONVERT, 8'he3);
    send_request(OP_CONVERT, 8'h0a);
    send_request(OP_FLUSH, 8'h5a);
    send_request(OP_CONVERT, 8'h31);
  endtask

  // Random text: ASCII runs and GB2312 pairs, with flushes and stray bytes
  task automatic test_random_text(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          b = 8'($urandom_range(0, 127));
          send_request(OP_CONVERT, b);
        end
        sent += len;
      end else if (pick < 85) begin
        len = $urandom_range(1, 4);
        repeat (2 * len) begin
          b = 8'($urandom_range(128, 255));
          send_request(OP_CONVERT, b);
        end
        sent += 2 * len;
      end else if (pick < 92) begin
        b = 8'($urandom_range(0, 255));
        send_request(OP_FLUSH, b);
        sent++;
      end else begin
        // stray byte, breaks pair alignment
        b = 8'($urandom_range(0, 255));
        send_request(OP_CONVERT, b);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_ascii_echo();
    test_double_byte();
    test_illegal_ascii();
    test_flush();
    idle_on = 1'b0;
    stall_on = 1'b0;
    test_random_text(55);
    wait_drained();
    idle_on = 1'b1;
    stall_on = 1'b1;
    test_random_text(150);
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && iso_bytes_due.size() == 0) begin
      $display("[euc_cn_to_iso2022_cn_encoder] OK");
    end else begin
      $display("[euc_cn_to_iso2022_cn_encoder] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d results still due", $time, iso_bytes_due.size());
    $display("[euc_cn_to_iso2022_cn_encoder] ERROR");
    $finish;
  end

endmodule
